[rtl/grid_manhattan_distance_map_top_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the Manhattan distance map
// Short forms for the concurrent checks on the block's ports.
// ----------------------------------------------------------------------------
`ifndef GRID_MANHATTAN_DISTANCE_MAP_TOP_ASSERT_SVH
`define GRID_MANHATTAN_DISTANCE_MAP_TOP_ASSERT_SVH

// Overlapping implication, checked on every rising edge outside reset.
`define GMDM_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication that is checked in the cycle after the antecedent.
`define GMDM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/gmdm_pkg.sv]
// ----------------------------------------------------------------------------
// Manhattan distance map package
// Types, codes and helpers shared by the distance map and its checker.
// ----------------------------------------------------------------------------
package gmdm_pkg;

  // Width of the size registers and of a distance.
  localparam int CFG_W     = 7;
  localparam int CFG_IDX_W = 1;
  localparam int DIST_W    = 7;

  localparam logic [DIST_W-1:0] DIST_SAT = 7'd127;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_COLUMN_COUNT = 1'b1;

  // Item kinds on the input channel.
  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_READ = 1'b1;

  // Sequencer states: idle, then a read and a write phase per cell and sweep.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FWD_RD,
    ST_FWD_WR,
    ST_BWD_RD,
    ST_BWD_WR
  } gmdm_state_t;

  // Saturating increment of a distance.
  function automatic logic [DIST_W-1:0] sat_inc(input logic [DIST_W-1:0] d);
    sat_inc = (d >= DIST_SAT) ? DIST_SAT : d + 7'd1;
  endfunction

endpackage

[rtl/grid_manhattan_distance_map_top.sv]
// A load is written to the cell store on acceptance; a read's result goes through the
// registered store read into the output register. One load per cycle while idle with no
// fetch pending; a read blocks new items during its fetch. The last load starts two raster
// sweeps, a read and a write state per cell; both run on the one shared compare unit and store.
// Reset (rst_n, synchronous, active low) clears positions, flags and the output stage, and
// sets both sizes to 64; the cell and distance stores are not cleared.
// ----------------------------------------------------------------------------
// Manhattan distance map, 4-connected
// Loads a binary grid, computes the distance of every cell to the nearest
// zero cell with a forward and a backward raster sweep, and reads it back.
// ----------------------------------------------------------------------------
module grid_manhattan_distance_map_top
  import gmdm_pkg::*;
#(
  parameter int MAX_ROWS    = 64,
  parameter int MAX_COLUMNS = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // Configuration write port
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  // Input channel
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [7:0]           in_tdata,   // [0] cell_value, [7:1] zero
  input  logic                 in_tuser,   // [0] kind
  input  logic                 in_tlast,
  // Result channel
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [7:0]           out_tdata,  // [6:0] distance, [7] zero
  output logic                 out_tuser,  // [0] unreachable
  output logic                 out_tlast
);

  localparam int CELLS  = MAX_ROWS * MAX_COLUMNS;
  localparam int ADDR_W = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int POS_W  = $clog2(CELLS + 1);

  localparam logic [8:0] MAX_R = 9'(MAX_ROWS);
  localparam logic [8:0] MAX_C = 9'(MAX_COLUMNS);

  // Storage
  logic              cell_mem [CELLS];
  logic [DIST_W-1:0] dist_mem [CELLS];

  // Control and datapath registers
  gmdm_state_t       state_r, state_nxt;
  logic [CFG_W-1:0]  row_count_r, column_count_r;
  logic [POS_W-1:0]  load_pos_r, read_pos_r, addr_r;
  logic [CFG_W-1:0]  row_r, col_r;
  logic              any_zero_r;
  logic              fetch_r, fetch_last_r;
  logic              out_valid_r, out_unr_r, out_last_r;
  logic [DIST_W-1:0] out_dist_r;
  logic [DIST_W-1:0] dist_a_q_r, dist_b_q_r, prev_r;
  logic              cell_q_r;

  // Sizes in use and grid total
  logic [CFG_W-1:0]   rows_used, cols_used;
  logic [2*CFG_W-1:0] prod;
  logic [POS_W-1:0]   total, rd_pos_eff, addr_up, addr_dn;
  logic [ADDR_W-1:0]  rd_a_addr, rd_b_addr;
  logic               in_acc, load_acc, read_acc, rd_last;
  logic               fwd_done, bwd_done;

  // Shared compare unit
  logic [DIST_W-1:0] base, nb1, nb2, t1, t2, t12, dmin;
  logic              en1, en2;

  // Clamp the configured sizes to the range the store holds.
  always_comb begin
    if (row_count_r == '0) begin
      rows_used = 7'd1;
    end else if ({2'b00, row_count_r} > MAX_R) begin
      rows_used = CFG_W'(MAX_ROWS);
    end else begin
      rows_used = row_count_r;
    end
    if (column_count_r == '0) begin
      cols_used = 7'd1;
    end else if ({2'b00, column_count_r} > MAX_C) begin
      cols_used = CFG_W'(MAX_COLUMNS);
    end else begin
      cols_used = column_count_r;
    end
  end

  assign prod  = rows_used * cols_used;
  assign total = POS_W'(prod);

  // Handshake. A read needs the output stage free, a load does not.
  assign in_tready = (state_r == ST_IDLE) && !fetch_r &&
                     ((in_tuser == KIND_LOAD) || !out_valid_r || out_tready);
  assign in_acc    = in_tvalid && in_tready;
  assign load_acc  = in_acc && (in_tuser == KIND_LOAD);
  assign read_acc  = in_acc && (in_tuser == KIND_READ);

  // A read position out of range of the current size wraps to the start.
  assign rd_pos_eff = (read_pos_r >= total) ? '0 : read_pos_r;
  assign rd_last    = (rd_pos_eff + POS_W'(1)) == total;

  // Neighbour addresses above and below the current cell.
  assign addr_up = addr_r - POS_W'(cols_used);
  assign addr_dn = addr_r + POS_W'(cols_used);

  assign rd_a_addr = (state_r == ST_BWD_RD) ? addr_dn[ADDR_W-1:0] : addr_up[ADDR_W-1:0];
  assign rd_b_addr = (state_r == ST_BWD_RD) ? addr_r[ADDR_W-1:0] : rd_pos_eff[ADDR_W-1:0];

  assign fwd_done = (row_r == rows_used - 7'd1) && (col_r == cols_used - 7'd1);
  assign bwd_done = (row_r == '0) && (col_r == '0);

  // Operand selection for the shared unit.
  always_comb begin
    unique case (state_r)
      ST_FWD_WR: begin
        base = cell_q_r ? DIST_SAT : '0;
        nb1  = dist_a_q_r;
        en1  = (row_r != '0);
        nb2  = prev_r;
        en2  = (col_r != '0);
      end
      ST_BWD_WR: begin
        base = dist_b_q_r;
        nb1  = dist_a_q_r;
        en1  = (row_r != rows_used - 7'd1);
        nb2  = prev_r;
        en2  = (col_r != cols_used - 7'd1);
      end
      default: begin
        base = dist_b_q_r;
        nb1  = dist_a_q_r;
        en1  = 1'b0;
        nb2  = prev_r;
        en2  = 1'b0;
      end
    endcase
  end

  // Minimum of the own value and the incremented neighbours.
  assign t1   = en1 ? sat_inc(nb1) : DIST_SAT;
  assign t2   = en2 ? sat_inc(nb2) : DIST_SAT;
  assign t12  = (t1 < t2) ? t1 : t2;
  assign dmin = (t12 < base) ? t12 : base;

  // Next state of the sequencer.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (load_acc && in_tlast) state_nxt = ST_FWD_RD;
      ST_FWD_RD: state_nxt = ST_FWD_WR;
      ST_FWD_WR: state_nxt = fwd_done ? ST_BWD_RD : ST_FWD_RD;
      ST_BWD_RD: state_nxt = ST_BWD_WR;
      ST_BWD_WR: state_nxt = bwd_done ? ST_IDLE : ST_BWD_RD;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Store accesses: registered reads on every cycle, writes by the sweeps and loads.
  always_ff @(posedge clk) begin
    dist_a_q_r <= dist_mem[rd_a_addr];
    dist_b_q_r <= dist_mem[rd_b_addr];
    cell_q_r   <= cell_mem[addr_r[ADDR_W-1:0]];
    if (state_r == ST_FWD_WR || state_r == ST_BWD_WR) begin
      dist_mem[addr_r[ADDR_W-1:0]] <= dmin;
    end
    if (load_acc && (load_pos_r < total)) begin
      cell_mem[load_pos_r[ADDR_W-1:0]] <= in_tdata[0];
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_count_r    <= 7'd64;
      column_count_r <= 7'd64;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ROW_COUNT:    row_count_r    <= cfg_wdata;
        REG_COLUMN_COUNT: column_count_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Load and read positions, and the zero-seen flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_pos_r <= '0;
      read_pos_r <= '0;
      any_zero_r <= 1'b0;
    end else if (load_acc) begin
      if (load_pos_r < total) begin
        load_pos_r <= load_pos_r + POS_W'(1);
        if (in_tdata[0] == 1'b0) begin
          any_zero_r <= 1'b1;
        end
      end
      // The last load restarts both positions; the sweep recomputes the flag.
      if (in_tlast) begin
        load_pos_r <= '0;
        read_pos_r <= '0;
        any_zero_r <= 1'b0;
      end
    end else if (read_acc) begin
      read_pos_r <= rd_last ? '0 : rd_pos_eff + POS_W'(1);
    end else if (state_r == ST_FWD_WR && !cell_q_r) begin
      any_zero_r <= 1'b1;
    end
  end

  // Sweep counters: row, column and linear address of the current cell.
  always_ff @(posedge clk) begin
    if (load_acc && in_tlast) begin
      row_r  <= '0;
      col_r  <= '0;
      addr_r <= '0;
    end else if (state_r == ST_FWD_WR) begin
      prev_r <= dmin;
      if (fwd_done) begin
        row_r  <= rows_used - 7'd1;
        col_r  <= cols_used - 7'd1;
        addr_r <= total - POS_W'(1);
      end else begin
        addr_r <= addr_r + POS_W'(1);
        if (col_r == cols_used - 7'd1) begin
          col_r <= '0;
          row_r <= row_r + 7'd1;
        end else begin
          col_r <= col_r + 7'd1;
        end
      end
    end else if (state_r == ST_BWD_WR) begin
      prev_r <= dmin;
      if (!bwd_done) begin
        addr_r <= addr_r - POS_W'(1);
        if (col_r == '0) begin
          col_r <= cols_used - 7'd1;
          row_r <= row_r - 7'd1;
        end else begin
          col_r <= col_r - 7'd1;
        end
      end
    end
  end

  // Read fetch and output stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fetch_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      fetch_r <= read_acc;
      if (fetch_r) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (read_acc) begin
      fetch_last_r <= rd_last;
    end
    if (fetch_r) begin
      out_dist_r <= dist_b_q_r;
      out_unr_r  <= !any_zero_r;
      out_last_r <= fetch_last_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_dist_r};
  assign out_tuser  = out_unr_r;
  assign out_tlast  = out_last_r;

endmodule

[rtl/gmdm_checker.sv]
// ----------------------------------------------------------------------------
// Manhattan distance map port checker
// Watches the ports of the distance map and flags broken timing or protocol.
// ----------------------------------------------------------------------------
`include "grid_manhattan_distance_map_top_assert.svh"

module gmdm_checker
  import gmdm_pkg::*;
(
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_tvalid,
  input logic                 in_tready,
  input logic                 in_tuser,   // [0] kind
  input logic                 out_tvalid,
  input logic                 out_tready,
  input logic [7:0]           out_tdata,  // [6:0] distance, [7] zero
  input logic                 out_tuser,  // [0] unreachable
  input logic                 out_tlast
);

  logic read_acc;

  // A read item is one accepted with the read kind.
  assign read_acc = in_tvalid && in_tready && (in_tuser == KIND_READ);

  // A stalled result keeps its payload.
  `GMDM_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast), "stalled result changed")

  // The cycle after a read item the block takes nothing while it fetches.
  `GMDM_ASSERT_NEXT(a_fetch_busy, read_acc, !in_tready, "item taken during a fetch")

  // Every read item shows a result after its fetch.
  `GMDM_ASSERT_IMP(a_read_result, read_acc, ##2 out_tvalid, "read item gave no result")

endmodule

bind grid_manhattan_distance_map_top gmdm_checker u_gmdm_checker (.*);

[test/grid_manhattan_distance_map_top_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Manhattan distance map testbench
// Loads binary grids over the input stream, reads the distance maps back and
// compares every result item with an in-bench predictor of the two sweeps.
// A short table of directed items comes first, then random grids under three
// stall profiles and one tall grid of two columns with a single corner zero.
// ----------------------------------------------------------------------------
module grid_manhattan_distance_map_top_tb;
  import gmdm_pkg::*;

  localparam int GRID_ROWS = 64;
  localparam int GRID_COLS = 64;
  localparam int GRID_CELLS = GRID_ROWS * GRID_COLS;
  localparam int TALL_ROWS = 64;
  localparam int TALL_COLS = 2;
  localparam int TALL_CELLS = TALL_ROWS * TALL_COLS;
  localparam int PHASE_ITEMS = 320;

  // One result item: distance, unreachable flag and end-of-grid marker.
  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic              unreach;
    logic              rlast;
  } dist_res_t;

  // One row of the directed part; the expected fields count only when typed.
  typedef struct packed {
    logic              kind;
    logic              cell_val;
    logic              tlast;
    logic              typed;
    logic [DIST_W-1:0] distance;
    logic              unreach;
    logic              rlast;
  } dir_row_t;

  // Grid of 1 x 3: saturation, loads past the grid, early last, read wrap,
  // and the unreachable flag following a load of a zero cell.
  localparam dir_row_t DIRECTED_ITEMS [25] = '{
    '{KIND_LOAD, 1'b1, 1'b0, 1'b0, 7'd0,   1'b0, 1'b0},
    '{KIND_LOAD, 1'b1, 1'b0, 1'b0, 7'd0,   1'b0, 1'b0},
    '{KIND_LOAD, 1'b1, 1'b1, 1'b0, 7'd0,   1'b0, 1'b0},
    '{KIND_READ, 1'b0, 1'b0, 1'b1, 7'd127, 1'b1, 1'b0},
    '{KIND_READ, 1'b1, 1'b1, 1'b1, 7'd127, 1'b1, 1'b0},
    '{KIND_READ, 1'b0, 1'b0, 1'b1, 7'd127, 1'b1, 1'b1},
    '{KIND_LOAD, 1'b0, 1'b0, 1'b0, 7'd0,   1'b0, 1'b0},
    '{KIND_LOAD, 1'b1, 1'b0, 1'b0, 7'd0,   1'b0, 1'b0},
    '{KIND_LOAD, 1'b1, 1'b0, 1'b0, 7'd0,   1'b0, 1'b0},
    '{KIND_LOAD, 1'b1, 1'b0, 1'b0, 7'd0,   1'b0, 1'b0},
    '{KIND_LOAD, 1'b1, 1'b1, 1'b0, 7'd0,   1'b0, 1'b0},
    '{KIND_READ, 1'b0, 1'b0, 1'b0, 7'd0,   1'b0, 1'b0},
    '{KIND_READ, 1'b0, 1'b0, 1'b0, 7'd0,   1'b0, 1'b0},
    '{KIND_READ, 1'b0, 1'b0, 1'b0, 7'd0,   1'b0, 1'b0},
    '{KIND_READ, 1'b0, 1'b0, 1'b0, 7'd0,   1'b0, 1'b0},
    '{KIND_LOAD, 1'b1, 1'b1, 1'b0, 7'd0,   1'b0, 1'b0},
    '{KIND_READ, 1'b0, 1'b0, 1'b1, 7'd127, 1'b1, 1'b0},
    '{KIND_READ, 1'b0, 1'b0, 1'b1, 7'd127, 1'b1, 1'b0},
    '{KIND_LOAD, 1'b0, 1'b0, 1'b0, 7'd0,   1'b0, 1'b0},
    '{KIND_READ, 1'b1, 1'b1, 1'b0, 7'd0,   1'b0, 1'b0},
    '{KIND_LOAD, 1'b1, 1'b0, 1'b0, 7'd0,   1'b0, 1'b0},
    '{KIND_LOAD, 1'b0, 1'b1, 1'b0, 7'd0,   1'b0, 1'b0},
    '{KIND_READ, 1'b0, 1'b0, 1'b0, 7'd0,   1'b0, 1'b0},
    '{KIND_READ, 1'b0, 1'b0, 1'b0, 7'd0,   1'b0, 1'b0},
    '{KIND_READ, 1'b0, 1'b0, 1'b0, 7'd0,   1'b0, 1'b0}
  };

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;
  logic                 in_tvalid;
  logic                 in_tready;
  logic [7:0]           in_tdata;   // [0] cell_value, [7:1] zero
  logic                 in_tuser;   // [0] kind
  logic                 in_tlast;
  logic                 out_tvalid;
  logic                 out_tready;
  logic [7:0]           out_tdata;  // [6:0] distance, [7] zero
  logic                 out_tuser;  // [0] unreachable
  logic                 out_tlast;

  // Predictor state: stored grid, distance map, positions and sizes.
  logic              map_cell [GRID_CELLS];
  logic [DIST_W-1:0] map_dist [GRID_CELLS];
  int                load_pos;
  int                read_pos;
  int                cells_hi;   // cells below this index have been loaded once
  int                dists_hi;   // distances below this index have been computed once
  bit                zero_seen;
  logic [CFG_W-1:0]  rows_reg;
  logic [CFG_W-1:0]  cols_reg;

  dist_res_t pending_distances [$];
  int        mismatch_count;
  int        items_sent;
  int        send_idle;
  int        recv_idle;

  grid_manhattan_distance_map_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // Clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard limit on the run.
  initial begin
    #20_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // Size in use: zero acts as one, anything above the maximum as the maximum.
  function automatic int used_dim(input logic [CFG_W-1:0] v, input int maxv);
    if (v == 0) return 1;
    if (v > maxv) return maxv;
    return v;
  endfunction

  function automatic int grid_total();
    return used_dim(rows_reg, GRID_ROWS) * used_dim(cols_reg, GRID_COLS);
  endfunction

  // Distance one step further on, held at saturation.
  function automatic logic [DIST_W-1:0] next_dist(input logic [DIST_W-1:0] d);
    return (d >= DIST_SAT) ? DIST_SAT : d + 7'd1;
  endfunction

  // Forward sweep from above and left, then backward sweep from below and right.
  function automatic void rebuild_distance_map();
    int rows;
    int cols;
    int idx;
    logic [DIST_W-1:0] d;
    rows = used_dim(rows_reg, GRID_ROWS);
    cols = used_dim(cols_reg, GRID_COLS);
    zero_seen = 1'b0;
    for (int r = 0; r < rows; r++) begin
      for (int c = 0; c < cols; c++) begin
        idx = r * cols + c;
        if (map_cell[idx] == 1'b0) begin
          d = '0;
          zero_seen = 1'b1;
        end else begin
          d = DIST_SAT;
          if (r > 0 && next_dist(map_dist[idx - cols]) < d) d = next_dist(map_dist[idx - cols]);
          if (c > 0 && next_dist(map_dist[idx - 1]) < d) d = next_dist(map_dist[idx - 1]);
        end
        map_dist[idx] = d;
      end
    end
    for (int r = rows - 1; r >= 0; r--) begin
      for (int c = cols - 1; c >= 0; c--) begin
        idx = r * cols + c;
        d = map_dist[idx];
        if (r + 1 < rows && next_dist(map_dist[idx + cols]) < d) d = next_dist(map_dist[idx + cols]);
        if (c + 1 < cols && next_dist(map_dist[idx + 1]) < d) d = next_dist(map_dist[idx + 1]);
        map_dist[idx] = d;
      end
    end
  endfunction

  // Advances the predictor by one accepted item; a read gives one result.
  function automatic void apply_item(input logic kind, input logic cell_val, input logic tlast,
                                     output bit has_res, output dist_res_t res);
    int total;
    total = grid_total();
    has_res = 1'b0;
    res = '0;
    if (kind == KIND_LOAD) begin
      if (load_pos < total) begin
        map_cell[load_pos] = cell_val;
        if (cell_val == 1'b0) zero_seen = 1'b1;
        load_pos++;
        if (load_pos > cells_hi) cells_hi = load_pos;
      end
      if (tlast) begin
        rebuild_distance_map();
        if (total > dists_hi) dists_hi = total;
        load_pos = 0;
        read_pos = 0;
      end
    end else begin
      if (read_pos >= total) read_pos = 0;
      res.distance = map_dist[read_pos];
      res.unreach  = !zero_seen;
      res.rlast    = (read_pos + 1 == total);
      read_pos     = (read_pos + 1 == total) ? 0 : read_pos + 1;
      has_res      = 1'b1;
    end
  endfunction

  // A read must only reach computed distances, and a computation only loaded cells.
  function automatic bit read_allowed();
    return dists_hi >= grid_total();
  endfunction

  function automatic bit last_allowed();
    int hi;
    hi = cells_hi;
    if (load_pos < grid_total() && load_pos + 1 > hi) hi = load_pos + 1;
    return hi >= grid_total();
  endfunction

  // Drives one item, waits for its handshake and records what it should give.
  task automatic send_item(input logic kind, input logic cell_val, input logic tlast,
                           input bit typed, input dist_res_t typed_res);
    bit has_res;
    dist_res_t res;
    while ($urandom_range(0, 99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {7'd0, cell_val};
    in_tlast  <= tlast;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    apply_item(kind, cell_val, tlast, has_res, res);
    if (has_res) pending_distances.push_back(typed ? typed_res : res);
    items_sent++;
  endtask

  // Random item, turned into one that touches only defined store entries.
  task automatic issue_item(input logic kind, input logic cell_val, input logic tlast);
    logic k;
    logic l;
    k = kind;
    l = tlast;
    if (k == KIND_READ && !read_allowed()) k = KIND_LOAD;
    if (k == KIND_LOAD && l && !last_allowed()) l = 1'b0;
    send_item(k, cell_val, l, 1'b0, '0);
  endtask

  // Sender pause until every result is in and any computation has finished.
  task automatic settle();
    in_tvalid <= 1'b0;
    while (pending_distances.size() != 0) @(posedge clk);
    repeat (4 * grid_total() + 16) @(posedge clk);
  endtask

  task automatic set_size(input logic [CFG_W-1:0] rows, input logic [CFG_W-1:0] cols);
    cfg_we    <= 1'b1;
    cfg_index <= REG_ROW_COUNT;
    cfg_wdata <= rows;
    @(posedge clk);
    cfg_index <= REG_COLUMN_COUNT;
    cfg_wdata <= cols;
    @(posedge clk);
    cfg_we   <= 1'b0;
    rows_reg = rows;
    cols_reg = cols;
  endtask

  // Mostly small sizes, with zero, the maximum and out-of-range values now and then.
  function automatic logic [CFG_W-1:0] pick_dim();
    case ($urandom_range(0, 19))
      0:       return 7'd0;
      1:       return 7'($urandom_range(65, 127));
      2:       return 7'd64;
      3, 4:    return 7'($urandom_range(7, 63));
      default: return 7'($urandom_range(1, 6));
    endcase
  endfunction

  // New sizes, kept to at most 128 cells so that each grid stays short.
  task automatic new_size();
    logic [CFG_W-1:0] rows;
    logic [CFG_W-1:0] cols;
    rows = pick_dim();
    cols = pick_dim();
    if (used_dim(rows, GRID_ROWS) * used_dim(cols, GRID_COLS) > 128) begin
      if ($urandom_range(0, 1)) cols = 7'($urandom_range(0, 2));
      else rows = 7'($urandom_range(0, 2));
    end
    settle();
    set_size(rows, cols);
  endtask

  function automatic logic rand_cell(input int zero_pct);
    return ($urandom_range(0, 99) < zero_pct) ? 1'b0 : 1'b1;
  endfunction

  // One random grid: mostly a full load and read-back, else noise, an early
  // last, or loads that run past the end of the grid.
  task automatic run_grid();
    int mode;
    int total;
    int n;
    int k;
    int zero_pct;
    total = grid_total();
    mode = $urandom_range(0, 9);
    case ($urandom_range(0, 4))
      0:       zero_pct = 0;
      1:       zero_pct = 3;
      2:       zero_pct = 15;
      3:       zero_pct = 50;
      default: zero_pct = 100;
    endcase
    if (mode <= 6 || mode == 9) begin
      n = (load_pos < total) ? total - load_pos : 1;
      for (int i = 0; i < n; i++)
        issue_item(KIND_LOAD, rand_cell(zero_pct), (i == n - 1) && mode != 9);
      if (mode == 9) begin
        k = $urandom_range(1, 3);
        for (int i = 0; i < k; i++) issue_item(KIND_LOAD, rand_cell(zero_pct), i == k - 1);
      end
      n = total;
      if ($urandom_range(0, 3) == 0) n += $urandom_range(1, 3);
      for (int i = 0; i < n; i++)
        issue_item(KIND_READ, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    end else if (mode == 7) begin
      k = $urandom_range(5, 20);
      for (int i = 0; i < k; i++)
        issue_item(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                   $urandom_range(0, 6) == 0);
    end else begin
      k = $urandom_range(0, total - 1);
      for (int i = 0; i <= k; i++) issue_item(KIND_LOAD, rand_cell(zero_pct), i == k);
      n = $urandom_range(1, total);
      for (int i = 0; i < n; i++)
        issue_item(KIND_READ, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    end
  endtask

  // Result side: random stalls.
  always @(posedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= recv_idle);
  end

  // Result side: each accepted item against the oldest expectation.
  always @(posedge clk) begin
    dist_res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_distances.size() == 0) begin
        mismatch_count++;
        $display("%0t: result with none expected, expected none, actual distance %0d",
                 $time, out_tdata[6:0]);
      end else begin
        want = pending_distances.pop_front();
        if (out_tdata[6:0] !== want.distance) begin
          mismatch_count++;
          $display("%0t: distance mismatch, expected %0d, actual %0d",
                   $time, want.distance, out_tdata[6:0]);
        end
        if (out_tuser !== want.unreach) begin
          mismatch_count++;
          $display("%0t: unreachable mismatch, expected %0b, actual %0b",
                   $time, want.unreach, out_tuser);
        end
        if (out_tlast !== want.rlast) begin
          mismatch_count++;
          $display("%0t: last marker mismatch, expected %0b, actual %0b",
                   $time, want.rlast, out_tlast);
        end
      end
    end
  end

  // Stimulus.
  initial begin
    dist_res_t typed_res;
    int phase_start;
    int drain_cycles;
    rst_n      = 1'b0;
    cfg_we     = 1'b0;
    cfg_index  = REG_ROW_COUNT;
    cfg_wdata  = '0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = KIND_LOAD;
    in_tlast   = 1'b0;
    load_pos   = 0;
    read_pos   = 0;
    cells_hi   = 0;
    dists_hi   = 0;
    zero_seen  = 1'b0;
    rows_reg   = 7'd64;
    cols_reg   = 7'd64;
    mismatch_count = 0;
    items_sent = 0;
    send_idle  = 6;
    recv_idle  = 70;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part on a grid of one row and three columns.
    set_size(7'd1, 7'd3);
    foreach (DIRECTED_ITEMS[i]) begin
      typed_res = {DIRECTED_ITEMS[i].distance, DIRECTED_ITEMS[i].unreach,
                   DIRECTED_ITEMS[i].rlast};
      send_item(DIRECTED_ITEMS[i].kind, DIRECTED_ITEMS[i].cell_val, DIRECTED_ITEMS[i].tlast,
                DIRECTED_ITEMS[i].typed, typed_res);
    end

    // Random part: slow receiver, then slow sender, then no stalls at all.
    for (int phase = 0; phase < 3; phase++) begin
      new_size();
      if (phase == 2) begin
        // Tall grid of 64 rows and 2 columns with a single zero in the corner.
        send_idle = 0;
        recv_idle = 0;
        settle();
        set_size(7'(TALL_ROWS), 7'(TALL_COLS));
        for (int i = 0; i < TALL_CELLS; i++)
          issue_item(KIND_LOAD, i != 0, i == TALL_CELLS - 1);
        for (int i = 0; i < TALL_CELLS; i++)
          issue_item(KIND_READ, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        new_size();
      end
      phase_start = items_sent;
      while (items_sent - phase_start < PHASE_ITEMS) begin
        if ($urandom_range(0, 3) == 0 || phase == 2) begin
          send_idle = 0;
          recv_idle = 0;
        end else begin
          send_idle = (phase == 0) ? 6 : 70;
          recv_idle = (phase == 0) ? 70 : 6;
        end
        if ($urandom_range(0, 2) == 0) new_size();
        else if ($urandom_range(0, 9) == 0) settle();
        run_grid();
      end
    end

    // Drain and report.
    in_tvalid <= 1'b0;
    drain_cycles = 0;
    while (pending_distances.size() != 0 && drain_cycles < 100000) begin
      @(posedge clk);
      drain_cycles++;
    end
    repeat (16) @(posedge clk);
    if (pending_distances.size() != 0)
      $display("%0t: %0d expected results never arrived", $time, pending_distances.size());
    if (mismatch_count == 0 && pending_distances.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
